// File: src/set_assoc_cache_hit_model_core_defines.svh
// Assertion macros for the set-associative cache hit model core.
// Used by set_assoc_cache_hit_model_core.sv; no other dependencies.
`ifndef SET_ASSOC_CACHE_HIT_MODEL_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_HIT_MODEL_CORE_DEFINES_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define SACH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define SACH_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SACH_ASSERT(lbl, prop, msg)
`define SACH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/sach_pkg.sv
// Shared constants for the set-associative cache hit model core.
// No dependencies.
`timescale 1ns / 1ps

package sach_pkg;

   localparam int LINES_DEFAULT     = 32;
   localparam int ADDR_BITS_DEFAULT = 32;

   // Widths fixed by the register and beat fields.
   localparam int ADDR_W      = 32;
   localparam int LINE_OUT_W  = 5;
   localparam int COUNT_W     = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 3;
   localparam int AGE_W       = 5;
   localparam int WAY_W       = 6;
   localparam int LFSR_W      = 16;

   localparam int WAYS_LOG2_MAX = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_LOG2    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_MODE = 1'b1;

   localparam logic [AGE_W-1:0]   AGE_MAX   = 5'd31;
   localparam logic [LFSR_W-1:0]  LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0]  LFSR_MASK = 16'hB400;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic MODE_LRU = 1'b0;

   typedef logic [LFSR_W-1:0] lfsr_type;

   // One Galois step of the victim LFSR.
   function automatic lfsr_type lfsr_next(input lfsr_type cur);
      lfsr_type nxt;
      nxt = cur >> 1;
      if (cur[0]) begin
         nxt = nxt ^ LFSR_MASK;
      end
      return nxt;
   endfunction

endpackage

// File: src/set_assoc_cache_hit_model_core.sv
// Set-associative cache hit model: one address per beat, one hit/line/total result per beat.
// Each beat runs the bit-serial set index remainder over the low min(ADDR_BITS,32) address bits,
// then walks the set through the single read port of the tag and age memories (reading each
// way in turn, checking the last way read and leaving the walk), then takes the fill step,
// which waits while the previous result is still unaccepted, and returns to the accept state.
// Addresses are taken only in the accept state, so beats never overlap.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed after reset.
// Depends on sach_pkg and set_assoc_cache_hit_model_core_defines.svh.
`timescale 1ns / 1ps
`include "set_assoc_cache_hit_model_core_defines.svh"

module set_assoc_cache_hit_model_core #(
   parameter int LINES     = sach_pkg::LINES_DEFAULT,
   parameter int ADDR_BITS = sach_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sach_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sach_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sach_pkg::ADDR_W-1:0]       req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [sach_pkg::LINE_OUT_W-1:0]   rsp_line,
   output logic [sach_pkg::COUNT_W-1:0]      rsp_hit_count,
   output logic [sach_pkg::COUNT_W-1:0]      rsp_access_count
);
   import sach_pkg::*;

   localparam int TAG_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int LINE_W   = $clog2(LINES);
   localparam int BIT_W    = $clog2(TAG_BITS);
   localparam int LG_FLOOR = $clog2(LINES + 1) - 1;
   localparam int LG_MAX   = (LG_FLOOR < WAYS_LOG2_MAX) ? LG_FLOOR : WAYS_LOG2_MAX;
   localparam logic [LINE_W:0] LINES_V = (LINE_W+1)'(LINES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MOD  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_FILL = 2'd3;

   // Configuration.
   logic [CSR_DATA_W-1:0] ways_log2_ff;
   logic                  replace_mode_ff;

   // Sequencer and per-beat working registers.
   logic [1:0]          state_ff, state_in;
   logic [TAG_BITS-1:0] addr_ff;
   logic [2:0]          lg_ff;
   logic [LINE_W:0]     sets_ff;
   logic [WAY_W-1:0]    ways_ff;
   logic [LINE_W:0]     rem_ff, rem_in;
   logic [BIT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [LINE_W-1:0]   base_ff, base_in;
   logic [WAY_W-1:0]    iss_cnt_ff, iss_cnt_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [LINE_W-1:0]   chk_idx_ff, chk_idx_in;
   logic                hit_ff, hit_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic                inv_found_ff, inv_found_in;
   logic [LINE_W-1:0]   inv_line_ff, inv_line_in;
   logic [AGE_W-1:0]    best_ff, best_in;
   logic [LINE_W-1:0]   best_line_ff, best_line_in;

   // Architectural state.
   lfsr_type            lfsr_ff;
   logic [COUNT_W-1:0]  hit_total_ff, access_total_ff;
   logic [LINES-1:0]    valid_ff;

   // Memories and their registered read data.
   logic [TAG_BITS-1:0] tag_mem [LINES];
   logic [AGE_W-1:0]    age_mem [LINES];
   logic [TAG_BITS-1:0] tag_rd_ff;
   logic [AGE_W-1:0]    age_rd_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [LINE_OUT_W-1:0] rsp_line_ff;
   logic [COUNT_W-1:0]    rsp_hit_count_ff, rsp_access_count_ff;

   logic                  req_fire;
   logic [2:0]            lg_cap;
   logic [LINE_W:0]       rem_step;
   logic                  issue;
   logic [LINE_W+WAY_W-1:0] rd_sum, rnd_sum;
   logic [LINE_W-1:0]     rd_idx;
   logic [WAY_W-1:0]      way_mask;
   logic                  lru;
   logic                  chk_line_valid, chk_match;
   logic [AGE_W-1:0]      aged;
   logic                  age_we;
   logic [LINE_W-1:0]     age_waddr;
   logic [AGE_W-1:0]      age_wdata;
   logic                  fill_go, fill_we, rnd_pick;
   logic [LINE_W-1:0]     victim;
   logic [LINE_W+LINE_OUT_W-1:0] victim_ext;
   logic [COUNT_W-1:0]    hit_total_in, access_total_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign lru       = (replace_mode_ff == MODE_LRU);

   // Values 6 and 7, and sets wider than the cache, fold down to the largest usable way count.
   assign lg_cap = (ways_log2_ff > 3'(LG_MAX)) ? 3'(LG_MAX) : ways_log2_ff;

   // One restoring step of the address-mod-sets remainder, most significant bit first.
   always_comb begin
      rem_step = {rem_ff[LINE_W-1:0], addr_ff[bit_cnt_ff]};
      if (rem_step >= sets_ff) begin
         rem_step = rem_step - sets_ff;
      end
   end

   assign issue    = (state_ff == ST_SCAN) && (iss_cnt_ff != ways_ff);
   assign rd_sum   = {{WAY_W{1'b0}}, base_ff} + {{LINE_W{1'b0}}, iss_cnt_ff};
   assign rd_idx   = rd_sum[LINE_W-1:0];
   assign way_mask = ways_ff - WAY_W'(1);
   assign rnd_sum  = {{WAY_W{1'b0}}, base_ff}
                   + {{LINE_W{1'b0}}, lfsr_ff[WAY_W-1:0] & way_mask};

   // Check stage: works on the way whose tag and age were read last cycle.
   assign chk_line_valid = valid_ff[chk_idx_ff];
   assign chk_match = chk_vld_ff && chk_line_valid && !hit_ff && (tag_rd_ff == addr_ff);
   assign aged = (age_rd_ff < AGE_MAX) ? (age_rd_ff + AGE_W'(1)) : age_rd_ff;

   assign rnd_pick = !hit_ff && !inv_found_ff && !lru;
   always_comb begin
      if (hit_ff) begin
         victim = line_ff;
      end else if (inv_found_ff) begin
         victim = inv_line_ff;
      end else if (lru) begin
         victim = best_line_ff;
      end else begin
         victim = rnd_sum[LINE_W-1:0];
      end
   end
   assign victim_ext = {{LINE_OUT_W{1'b0}}, victim};

   assign fill_go = (state_ff == ST_FILL) && !(rsp_valid_ff && !rsp_ready);
   assign fill_we = fill_go && !hit_ff;

   always_comb begin
      age_we    = 1'b0;
      age_waddr = chk_idx_ff;
      age_wdata = aged;
      if (fill_we) begin
         age_we    = 1'b1;
         age_waddr = victim;
         age_wdata = '0;
      end else if (chk_vld_ff && chk_line_valid && lru) begin
         age_we    = chk_match || (age_rd_ff < AGE_MAX);
         age_wdata = chk_match ? '0 : aged;
      end
   end

   assign hit_total_in = (hit_ff && (hit_total_ff != COUNT_MAX))
                       ? (hit_total_ff + COUNT_W'(1)) : hit_total_ff;
   assign access_total_in = (access_total_ff != COUNT_MAX)
                          ? (access_total_ff + COUNT_W'(1)) : access_total_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      base_in      = base_ff;
      iss_cnt_in   = iss_cnt_ff;
      chk_vld_in   = issue;
      chk_idx_in   = rd_idx;
      hit_in       = hit_ff;
      line_in      = line_ff;
      inv_found_in = inv_found_ff;
      inv_line_in  = inv_line_ff;
      best_in      = best_ff;
      best_line_in = best_line_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in   = ST_MOD;
               rem_in     = '0;
               bit_cnt_in = BIT_W'(TAG_BITS - 1);
            end
         end
         ST_MOD: begin
            rem_in     = rem_step;
            bit_cnt_in = bit_cnt_ff - BIT_W'(1);
            if (bit_cnt_ff == '0) begin
               state_in     = ST_SCAN;
               base_in      = rem_step[LINE_W-1:0] << lg_ff;
               iss_cnt_in   = '0;
               hit_in       = 1'b0;
               line_in      = rem_step[LINE_W-1:0] << lg_ff;
               inv_found_in = 1'b0;
               best_in      = '0;
               best_line_in = rem_step[LINE_W-1:0] << lg_ff;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               iss_cnt_in = iss_cnt_ff + WAY_W'(1);
            end
            if (chk_match) begin
               hit_in  = 1'b1;
               line_in = chk_idx_ff;
            end
            if (chk_vld_ff && !chk_line_valid && !inv_found_ff) begin
               inv_found_in = 1'b1;
               inv_line_in  = chk_idx_ff;
            end
            // On a full set every valid way has been aged, so the aged value ranks the ways.
            if (chk_vld_ff && chk_line_valid && (aged > best_ff)) begin
               best_in      = aged;
               best_line_in = chk_idx_ff;
            end
            if (!issue && !chk_vld_ff) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (fill_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         chk_vld_ff      <= 1'b0;
         valid_ff        <= '0;
         lfsr_ff         <= LFSR_SEED;
         hit_total_ff    <= '0;
         access_total_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         ways_log2_ff    <= '0;
         replace_mode_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WAYS_LOG2:    ways_log2_ff    <= csr_wdata;
               CSR_REPLACE_MODE: replace_mode_ff <= csr_wdata[0];
               default:          ways_log2_ff    <= ways_log2_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && !fill_go) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fill_go) begin
            rsp_valid_ff    <= 1'b1;
            hit_total_ff    <= hit_total_in;
            access_total_ff <= access_total_in;
            if (fill_we) begin
               valid_ff[victim] <= 1'b1;
            end
            if (rnd_pick) begin
               lfsr_ff <= lfsr_next(lfsr_ff);
            end
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         addr_ff <= req_address[TAG_BITS-1:0];
         lg_ff   <= lg_cap;
         sets_ff <= LINES_V >> lg_cap;
         ways_ff <= WAY_W'(1) << lg_cap;
      end
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      base_ff      <= base_in;
      iss_cnt_ff   <= iss_cnt_in;
      chk_idx_ff   <= chk_idx_in;
      hit_ff       <= hit_in;
      line_ff      <= line_in;
      inv_found_ff <= inv_found_in;
      inv_line_ff  <= inv_line_in;
      best_ff      <= best_in;
      best_line_ff <= best_line_in;
      if (fill_go) begin
         rsp_hit_ff          <= hit_ff;
         rsp_line_ff         <= victim_ext[LINE_OUT_W-1:0];
         rsp_hit_count_ff    <= hit_total_in;
         rsp_access_count_ff <= access_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         tag_mem[victim] <= addr_ff;
      end
      tag_rd_ff <= tag_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (age_we) begin
         age_mem[age_waddr] <= age_wdata;
      end
      age_rd_ff <= age_mem[rd_idx];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_line         = rsp_line_ff;
   assign rsp_hit_count    = rsp_hit_count_ff;
   assign rsp_access_count = rsp_access_count_ff;

   `SACH_ASSERT(a_rsp_from_fill, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FILL), "result beat raised outside the fill step")
   `SACH_ASSERT(a_hits_le_access, rsp_valid_ff |-> (rsp_hit_count_ff <= rsp_access_count_ff), "hit total exceeds access total")
   `SACH_ASSERT(a_chk_in_set, chk_vld_ff |-> ((chk_idx_ff >= base_ff) && (state_ff == ST_SCAN)), "way check outside the current set")
   `SACH_ASSERT(a_lfsr_nonzero, lfsr_ff != '0, "victim LFSR reached the all-zero lockup state")

endmodule
